// File: sv/csi_pkg.sv
// Shared types and constants for the piecewise-linear color map.
// No dependencies; every other file takes its names by scope from here.
`default_nettype none
package csi_pkg;

	localparam int MAX_STOPS  = 3;
	localparam int NUM_STOPS  = 3;
	localparam int VAL_W      = 48;
	localparam int COL_W      = 32;
	localparam int CH_W       = 8;
	localparam int NUM_CH     = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;

	// one quotient bit per divider stage
	localparam int DIV_BITS     = CH_W;
	localparam int PROD_W       = VAL_W + CH_W;
	localparam int LERP_DEPTH   = DIV_BITS + 2;
	localparam int PIPE_LATENCY = LERP_DEPTH + 3;

	localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_0 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_1 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_2 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_0     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_1     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_2     = 3'd6;

	localparam logic [1:0] STOP_COUNT_RESET = 2'd2;
	localparam logic [1:0] STOP_COUNT_THREE = 2'd3;

	typedef struct packed {
		logic signed [VAL_W-1:0] val;
		logic                    cell_is_number;
	} sample_t;

	typedef struct packed {
		logic            colour_valid;
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] alpha;
	} colour_t;

	typedef struct packed {
		logic                              three_stops;
		logic [NUM_STOPS-1:0][VAL_W-1:0]  thr;
		logic [NUM_STOPS-1:0][COL_W-1:0]  col;
	} cfg_t;

	// segment decision handed to the channel lanes
	typedef struct packed {
		logic             vld;
		logic             num;
		logic             interp;
		logic [VAL_W-1:0] off;
		logic [VAL_W-1:0] span;
		logic [COL_W-1:0] col_a;
		logic [COL_W-1:0] col_b;
	} seg_t;

endpackage
`default_nettype wire

// File: sv/color_scale_interpolator_top.sv
// Piecewise-linear color map, top level; needs csi_pkg, csi_cfg, csi_seg, csi_lerp.
// An accepted sample passes the front registers s1..s3, the product register, the
// 8-stage divider (most of the depth) and the result register before done rises.
// Throughput: one sample per cycle while busy is low; the receiver cannot stall the pipe.
// Reset clears the beat valid bits (colour_valid is not reset) and loads register
// defaults; busy is set by reset and cleared by the clock edge that follows release.
`default_nettype none
module color_scale_interpolator_top (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire csi_pkg::sample_t                 sample,
	output logic                                  done,
	output csi_pkg::colour_t                      colour,
	input  wire logic                             cfg_we,
	input  wire logic [csi_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  wire logic [csi_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	localparam int LD = csi_pkg::LERP_DEPTH;
	localparam int CW = csi_pkg::CH_W;

	logic           busy_q;
	logic           accept;
	csi_pkg::cfg_t  cfg;
	csi_pkg::seg_t  seg;
	logic           vld_s [LD];
	logic           num_s [LD];
	logic [CW-1:0]  ch_res [csi_pkg::NUM_CH];

	assign accept = start && !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			busy_q <= 1'b1;
		else
			busy_q <= 1'b0;
	end

	csi_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	csi_seg u_seg (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.sample (sample),
		.cfg    (cfg),
		.seg    (seg)
	);

	for (genvar c = 0; c < csi_pkg::NUM_CH; c++) begin : g_ch
		csi_lerp u_lerp (
			.clk    (clk),
			.interp (seg.interp),
			.off    (seg.off),
			.span   (seg.span),
			.lo     (seg.col_a[csi_pkg::COL_W-1-CW*c -: CW]),
			.hi     (seg.col_b[csi_pkg::COL_W-1-CW*c -: CW]),
			.res    (ch_res[c])
		);
	end

	// beat tags ride alongside the channel lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LD; k++)
				vld_s[k] <= 1'b0;
		end else begin
			vld_s[0] <= seg.vld;
			for (int k = 1; k < LD; k++)
				vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		num_s[0] <= seg.num;
		for (int k = 1; k < LD; k++)
			num_s[k] <= num_s[k-1];
	end

	assign busy                = busy_q;
	assign done                = vld_s[LD-1];
	assign colour.colour_valid = num_s[LD-1];
	assign colour.red          = ch_res[0];
	assign colour.green        = ch_res[1];
	assign colour.blue         = ch_res[2];
	assign colour.alpha        = ch_res[3];

endmodule
`default_nettype wire

// File: sv/csi_cfg.sv
// Configuration register file: stop count, thresholds and stop colors.
// Depends on csi_pkg.
`default_nettype none
module csi_cfg (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [csi_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  wire logic [csi_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output csi_pkg::cfg_t                         cfg
);

	logic [1:0]                    stop_count_q;
	logic [csi_pkg::VAL_W-1:0]     thr_q [csi_pkg::NUM_STOPS];
	logic [csi_pkg::COL_W-1:0]     col_q [csi_pkg::NUM_STOPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_count_q <= csi_pkg::STOP_COUNT_RESET;
			for (int i = 0; i < csi_pkg::NUM_STOPS; i++) begin
				thr_q[i] <= '0;
				col_q[i] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_idx)
				csi_pkg::REG_STOP_COUNT:  stop_count_q <= cfg_wdata[1:0];
				csi_pkg::REG_THRESHOLD_0: thr_q[0] <= cfg_wdata[csi_pkg::VAL_W-1:0];
				csi_pkg::REG_THRESHOLD_1: thr_q[1] <= cfg_wdata[csi_pkg::VAL_W-1:0];
				csi_pkg::REG_THRESHOLD_2: thr_q[2] <= cfg_wdata[csi_pkg::VAL_W-1:0];
				csi_pkg::REG_COLOR_0:     col_q[0] <= cfg_wdata[csi_pkg::COL_W-1:0];
				csi_pkg::REG_COLOR_1:     col_q[1] <= cfg_wdata[csi_pkg::COL_W-1:0];
				csi_pkg::REG_COLOR_2:     col_q[2] <= cfg_wdata[csi_pkg::COL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		// counts below two act as two; three only if the stop limit allows it
		cfg.three_stops = (stop_count_q == csi_pkg::STOP_COUNT_THREE) &&
			(csi_pkg::MAX_STOPS >= 3);
		for (int i = 0; i < csi_pkg::NUM_STOPS; i++) begin
			cfg.thr[i] = thr_q[i];
			cfg.col[i] = col_q[i];
		end
	end

endmodule
`default_nettype wire

// File: sv/csi_seg.sv
// Front stages s1..s3: input register, threshold compares, segment pick.
// Depends on csi_pkg.
`default_nettype none
module csi_seg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire csi_pkg::sample_t  sample,
	input  wire csi_pkg::cfg_t     cfg,
	output csi_pkg::seg_t          seg
);

	localparam int VW = csi_pkg::VAL_W;

	logic                  vld_s1;
	logic signed [VW-1:0]  v_s1;
	logic                  num_s1;

	logic                  vld_s2;
	logic                  num_s2;
	logic                  le0_s2;
	logic                  gel_s2;
	logic                  in0_s2;
	logic                  in1_s2;
	logic [VW-1:0]         off0_s2;
	logic [VW-1:0]         off1_s2;
	logic [VW-1:0]         span0_s2;
	logic [VW-1:0]         span1_s2;

	logic                  vld_s3;
	csi_pkg::seg_t         seg_s3;
	csi_pkg::seg_t         seg_nx;

	logic signed [VW-1:0]  t0;
	logic signed [VW-1:0]  t1;
	logic signed [VW-1:0]  t2;
	logic signed [VW-1:0]  t_last;
	logic [csi_pkg::COL_W-1:0] col_last;

	assign t0       = cfg.thr[0];
	assign t1       = cfg.thr[1];
	assign t2       = cfg.thr[2];
	assign t_last   = cfg.three_stops ? t2 : t1;
	assign col_last = cfg.three_stops ? cfg.col[2] : cfg.col[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		v_s1   <= sample.val;
		num_s1 <= sample.cell_is_number;

		num_s2   <= num_s1;
		le0_s2   <= v_s1 <= t0;
		gel_s2   <= v_s1 >= t_last;
		in0_s2   <= (v_s1 >= t0) && (v_s1 <= t1);
		in1_s2   <= cfg.three_stops && (v_s1 >= t1) && (v_s1 <= t2);
		// only meaningful inside a segment, where they fit unsigned
		off0_s2  <= VW'((VW+1)'(v_s1) - (VW+1)'(t0));
		off1_s2  <= VW'((VW+1)'(v_s1) - (VW+1)'(t1));
		span0_s2 <= VW'((VW+1)'(t1) - (VW+1)'(t0));
		span1_s2 <= VW'((VW+1)'(t2) - (VW+1)'(t1));

		seg_s3 <= seg_nx;
	end

	// A zero-width segment never reaches interpolation: the value then sits
	// on an end stop and the first two tests already give that stop's color.
	always_comb begin
		seg_nx        = '0;
		seg_nx.num    = num_s2;
		seg_nx.off    = off0_s2;
		seg_nx.span   = span0_s2;
		seg_nx.col_a  = col_last;
		seg_nx.col_b  = col_last;
		if (!num_s2) begin
			seg_nx.col_a = '0;
			seg_nx.col_b = '0;
		end else if (le0_s2) begin
			seg_nx.col_a = cfg.col[0];
		end else if (gel_s2) begin
			seg_nx.col_a = col_last;
		end else if (in0_s2) begin
			seg_nx.interp = 1'b1;
			seg_nx.col_a  = cfg.col[0];
			seg_nx.col_b  = cfg.col[1];
		end else if (in1_s2) begin
			seg_nx.interp = 1'b1;
			seg_nx.off    = off1_s2;
			seg_nx.span   = span1_s2;
			seg_nx.col_a  = cfg.col[1];
			seg_nx.col_b  = cfg.col[2];
		end
	end

	always_comb begin
		seg     = seg_s3;
		seg.vld = vld_s3;
	end

endmodule
`default_nettype wire

// File: sv/csi_lerp.sv
// One color channel lane: off*|hi-lo| product, bit-per-stage restoring
// divide by segment span, round half up, move lo toward hi; pass lo if !interp.
// Depends on csi_pkg.
`default_nettype none
module csi_lerp (
	input  wire logic                       clk,
	input  wire logic                       interp,
	input  wire logic [csi_pkg::VAL_W-1:0]  off,
	input  wire logic [csi_pkg::VAL_W-1:0]  span,
	input  wire logic [csi_pkg::CH_W-1:0]   lo,
	input  wire logic [csi_pkg::CH_W-1:0]   hi,
	output logic      [csi_pkg::CH_W-1:0]   res
);

	localparam int VW = csi_pkg::VAL_W;
	localparam int CW = csi_pkg::CH_W;
	localparam int PW = csi_pkg::PROD_W;
	localparam int DB = csi_pkg::DIV_BITS;

	logic [CW:0]   diff;
	logic [CW-1:0] mag;

	// index k of these arrays is pipeline stage s4+k
	logic [PW-1:0] rem_s    [DB+1];
	logic [DB-1:0] quo_s    [DB+1];
	logic [VW-1:0] span_s   [DB+1];
	logic [CW-1:0] lo_s     [DB+1];
	logic          neg_s    [DB+1];
	logic          interp_s [DB+1];

	logic [PW:0]   trial  [DB];
	logic [DB-1:0] quo_nx [DB];

	logic [VW:0]   two_r;
	logic [VW:0]   span_x;
	logic          round_up;
	logic          round_dn;
	logic [CW+1:0] sum;
	logic [CW-1:0] res_s13;

	assign diff = {1'b0, hi} - {1'b0, lo};
	assign mag  = diff[CW] ? CW'(-diff) : diff[CW-1:0];

	always_comb begin
		for (int g = 0; g < DB; g++) begin
			trial[g]  = {1'b0, rem_s[g]} - ((PW+1)'(span_s[g]) << (DB - 1 - g));
			quo_nx[g] = quo_s[g] | (DB'(!trial[g][PW]) << (DB - 1 - g));
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0]    <= PW'(off) * PW'(mag);
		quo_s[0]    <= '0;
		span_s[0]   <= span;
		lo_s[0]     <= lo;
		neg_s[0]    <= diff[CW];
		interp_s[0] <= interp;
		for (int g = 0; g < DB; g++) begin
			rem_s[g+1]    <= trial[g][PW] ? rem_s[g] : trial[g][PW-1:0];
			quo_s[g+1]    <= quo_nx[g];
			span_s[g+1]   <= span_s[g];
			lo_s[g+1]     <= lo_s[g];
			neg_s[g+1]    <= neg_s[g];
			interp_s[g+1] <= interp_s[g];
		end
		res_s13 <= interp_s[DB] ? sum[CW-1:0] : lo_s[DB];
	end

	// remainder is below the span here; a tie rounds toward the larger value
	assign two_r    = {rem_s[DB][VW-1:0], 1'b0};
	assign span_x   = {1'b0, span_s[DB]};
	assign round_up = two_r >= span_x;
	assign round_dn = two_r > span_x;

	always_comb begin
		if (neg_s[DB])
			sum = (CW+2)'(lo_s[DB]) - (CW+2)'(quo_s[DB]) - (CW+2)'(round_dn);
		else
			sum = (CW+2)'(lo_s[DB]) + (CW+2)'(quo_s[DB]) + (CW+2)'(round_up);
	end

	assign res = res_s13;

endmodule
`default_nettype wire

// File: sv/csi_checker.sv
// Port-level checks for the color map top level, attached by bind.
// Depends on csi_pkg and color_scale_interpolator_top.
`default_nettype none
module csi_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             start,
	input wire logic             busy,
	input wire csi_pkg::sample_t sample,
	input wire logic             done,
	input wire csi_pkg::colour_t colour
);

	// every accepted beat comes out exactly at the pipeline latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(csi_pkg::PIPE_LATENCY) done)
		else $error("accepted beat did not complete on time");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, csi_pkg::PIPE_LATENCY))
		else $error("result without a matching accepted beat");

	a_non_number: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !sample.cell_is_number) |->
		##(csi_pkg::PIPE_LATENCY) (done && !colour.colour_valid))
		else $error("non-numeric beat produced a colour");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !colour.colour_valid) |->
		(colour.red == '0 && colour.green == '0 &&
		 colour.blue == '0 && colour.alpha == '0))
		else $error("invalid colour with nonzero channels");

endmodule

bind color_scale_interpolator_top csi_checker u_csi_checker (.*);
`default_nettype wire

// File: verif/tb_color_scale_interpolator_top.sv
// Self-checking testbench for color_scale_interpolator_top: random and directed
// samples across many stop settings, checked against an in-bench color map model.
// Depends on csi_pkg and the RTL under sv/.
`default_nettype none
module tb_color_scale_interpolator_top;

	localparam int VAL_W  = csi_pkg::VAL_W;
	localparam int COL_W  = csi_pkg::COL_W;
	localparam int CH_W   = csi_pkg::CH_W;
	localparam int NSTOP  = csi_pkg::NUM_STOPS;
	localparam int NCH    = csi_pkg::NUM_CH;
	localparam int IDX_W  = csi_pkg::CFG_IDX_W;
	localparam int DATA_W = csi_pkg::CFG_DATA_W;

	localparam longint VAL_MIN = -longint'(64'sd140737488355328);
	localparam longint VAL_MAX = 64'sd140737488355327;
	localparam longint Q_ONE   = 64'sd65536;
	localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int QUIET_LIMIT = 2000;
	localparam int RAND_PHASES = 12;
	localparam int PHASE_ITEMS = 50;

	// Expected colors and a private copy of the stop registers.
	class colour_board;
		logic [1:0]         stop_sel;
		logic [VAL_W-1:0]   thr[NSTOP];
		logic [COL_W-1:0]   col[NSTOP];
		csi_pkg::colour_t   pending_colours[$];
		int                 errs;
		int                 checked;
		int                 blended;
		int                 non_numeric;

		function new();
			stop_sel = csi_pkg::STOP_COUNT_RESET;
			for (int k = 0; k < NSTOP; k++) begin
				thr[k] = '0;
				col[k] = '0;
			end
			errs = 0;
			checked = 0;
			blended = 0;
			non_numeric = 0;
		endfunction

		function void apply_write(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
			case (idx)
				csi_pkg::REG_STOP_COUNT:  stop_sel = data[1:0];
				csi_pkg::REG_THRESHOLD_0: thr[0] = data;
				csi_pkg::REG_THRESHOLD_1: thr[1] = data;
				csi_pkg::REG_THRESHOLD_2: thr[2] = data;
				csi_pkg::REG_COLOR_0:     col[0] = data[COL_W-1:0];
				csi_pkg::REG_COLOR_1:     col[1] = data[COL_W-1:0];
				csi_pkg::REG_COLOR_2:     col[2] = data[COL_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [CH_W-1:0] mix_channel(longint lo, longint hi, longint off, longint span);
			longint acc;
			longint q;
			acc = lo * span + off * (hi - lo);
			if (acc < 0)
				acc = 0;
			q = (2 * acc + span) / (2 * span);
			if (q > 255)
				q = 255;
			return q[CH_W-1:0];
		endfunction

		function csi_pkg::colour_t predict_colour(csi_pkg::sample_t s);
			csi_pkg::colour_t c;
			int               n;
			longint           v;
			longint           t[NSTOP];
			longint           lo_t;
			longint           hi_t;
			logic [COL_W-1:0] pick;
			logic [CH_W-1:0]  ch[NCH];
			c = '0;
			if (!s.cell_is_number) begin
				non_numeric++;
				return c;
			end
			n = stop_sel;
			if (n < 2)
				n = 2;
			if (n > csi_pkg::MAX_STOPS)
				n = csi_pkg::MAX_STOPS;
			v = s.val;
			for (int k = 0; k < NSTOP; k++)
				t[k] = longint'($signed(thr[k]));
			c.colour_valid = 1'b1;
			pick = col[n-1];
			if (v <= t[0]) begin
				pick = col[0];
			end else if (v < t[n-1]) begin
				for (int i = 0; i + 1 < n; i++) begin
					lo_t = t[i];
					hi_t = t[i+1];
					if (v >= lo_t && v <= hi_t) begin
						if (hi_t == lo_t) begin
							pick = col[i+1];
							break;
						end
						for (int k = 0; k < NCH; k++)
							ch[k] = mix_channel(col[i][COL_W-1-CH_W*k -: CH_W],
							                    col[i+1][COL_W-1-CH_W*k -: CH_W],
							                    v - lo_t, hi_t - lo_t);
						{c.red, c.green, c.blue, c.alpha} = {ch[0], ch[1], ch[2], ch[3]};
						blended++;
						return c;
					end
				end
			end
			{c.red, c.green, c.blue, c.alpha} = pick;
			return c;
		endfunction

		function void note_sample(csi_pkg::sample_t s);
			csi_pkg::colour_t want;
			want = predict_colour(s);
			pending_colours = {pending_colours, want};
		endfunction

		function void check_field(string what, logic [CH_W-1:0] want, logic [CH_W-1:0] got);
			if (got !== want) begin
				errs++;
				if (errs <= 10)
					$display("MISMATCH %s: expected %02h, got %02h", what, want, got);
			end
		endfunction

		function void check_colour(csi_pkg::colour_t got);
			csi_pkg::colour_t want;
			if (pending_colours.size() == 0) begin
				errs++;
				if (errs <= 10)
					$display("MISMATCH: unexpected colour beat %h", got);
				return;
			end
			want = pending_colours.pop_front();
			checked++;
			check_field("colour_valid", CH_W'(want.colour_valid), CH_W'(got.colour_valid));
			check_field("red", want.red, got.red);
			check_field("green", want.green, got.green);
			check_field("blue", want.blue, got.blue);
			check_field("alpha", want.alpha, got.alpha);
		endfunction

		function bit idle();
			return pending_colours.size() == 0;
		endfunction

		function void close_out();
			if (pending_colours.size() != 0) begin
				errs += pending_colours.size();
				$display("MISSING: %0d colour beats never arrived", pending_colours.size());
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	csi_pkg::sample_t      sample = '0;
	logic                  done;
	csi_pkg::colour_t      colour;
	logic                  cfg_we = 1'b0;
	logic [IDX_W-1:0]      cfg_idx = '0;
	logic [DATA_W-1:0]     cfg_wdata = '0;

	colour_board sb;
	int          quiet = 0;
	int          settings_used = 0;
	int          samples_sent = 0;

	color_scale_interpolator_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.sample    (sample),
		.done      (done),
		.colour    (colour),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// watch both handshakes; results arrive a fixed latency after the input beat
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_sample(sample);
			if (done)
				sb.check_colour(colour);
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_we)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("Timeout: no beat for %0d cycles", QUIET_LIMIT);
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic longint clamp48(longint x);
		if (x < VAL_MIN)
			return VAL_MIN;
		if (x > VAL_MAX)
			return VAL_MAX;
		return x;
	endfunction

	function automatic longint rand48();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return longint'($signed(r[VAL_W-1:0]));
	endfunction

	function automatic longint rand_between(longint a, longint b);
		logic [63:0] w;
		logic [63:0] r;
		w = b - a;
		r = {$urandom, $urandom};
		if (w != '1)
			r = r % (w + 1);
		return clamp48(a + longint'(r));
	endfunction

	function automatic csi_pkg::sample_t make_sample(longint v, bit num);
		csi_pkg::sample_t s;
		s.val = v[VAL_W-1:0];
		s.cell_is_number = num;
		return s;
	endfunction

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		sb.apply_write(idx, data);
	endtask

	task automatic load_stops(logic [1:0] cnt, longint t0, longint t1, longint t2,
	                          logic [COL_W-1:0] c0, logic [COL_W-1:0] c1,
	                          logic [COL_W-1:0] c2, bit poke_unused);
		write_reg(csi_pkg::REG_STOP_COUNT, DATA_W'(cnt));
		write_reg(csi_pkg::REG_THRESHOLD_0, t0[VAL_W-1:0]);
		write_reg(csi_pkg::REG_THRESHOLD_1, t1[VAL_W-1:0]);
		write_reg(csi_pkg::REG_THRESHOLD_2, t2[VAL_W-1:0]);
		write_reg(csi_pkg::REG_COLOR_0, DATA_W'(c0));
		write_reg(csi_pkg::REG_COLOR_1, DATA_W'(c1));
		write_reg(csi_pkg::REG_COLOR_2, DATA_W'(c2));
		// index past the register list must not disturb anything
		if (poke_unused)
			write_reg(REG_UNUSED, DATA_W'({$urandom, $urandom}));
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic push_sample(csi_pkg::sample_t s, bit gaps);
		if (gaps && $urandom_range(0, 99) < 5) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		start <= 1'b1;
		sample <= s;
		do @(posedge clk); while (busy);
		samples_sent++;
	endtask

	// sender holds off until every pending color is back, then lets the pipe settle
	task automatic drain();
		start <= 1'b0;
		while (!sb.idle())
			@(posedge clk);
		repeat (csi_pkg::PIPE_LATENCY + 2) @(posedge clk);
	endtask

	task automatic run_random_phase(int count, bit gaps);
		longint           t[NSTOP];
		logic [COL_W-1:0] c[NSTOP];
		longint           lo_b;
		longint           hi_b;
		longint           margin;
		longint           v;
		longint           tmp;
		longint           scale;
		int               mode;
		int               sel;
		bit               num;
		mode = $urandom_range(0, 9);
		scale = longint'(1) << $urandom_range(4, 46);
		for (int k = 0; k < NSTOP; k++) begin
			if (mode == 0)
				t[k] = rand48();
			else if (mode == 1)
				t[k] = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
			else
				t[k] = rand_between(-scale, scale);
			case ($urandom_range(0, 7))
				0: c[k] = '0;
				1: c[k] = '1;
				default: c[k] = $urandom;
			endcase
		end
		// mostly ordered stops; the rest stay unordered
		if (mode >= 2 && mode <= 7) begin
			for (int p = 0; p < 2; p++)
				for (int k = 0; k + 1 < NSTOP; k++)
					if (t[k] > t[k+1]) begin
						tmp = t[k];
						t[k] = t[k+1];
						t[k+1] = tmp;
					end
		end
		load_stops(2'($urandom_range(0, 3)), t[0], t[1], t[2], c[0], c[1], c[2],
		           $urandom_range(0, 3) == 0);
		lo_b = t[0];
		hi_b = t[0];
		for (int k = 1; k < NSTOP; k++) begin
			if (t[k] < lo_b)
				lo_b = t[k];
			if (t[k] > hi_b)
				hi_b = t[k];
		end
		margin = (hi_b - lo_b) / 4 + 4;
		for (int i = 0; i < count; i++) begin
			sel = $urandom_range(0, 99);
			num = 1'b1;
			if (sel < 70)
				v = rand_between(clamp48(lo_b - margin), clamp48(hi_b + margin));
			else if (sel < 80)
				v = clamp48(t[$urandom_range(0, 2)] + longint'($urandom_range(0, 2)) - 1);
			else if (sel < 90)
				v = rand48();
			else begin
				v = rand48();
				num = 1'b0;
			end
			push_sample(make_sample(v, num), gaps);
		end
		drain();
	endtask

	initial begin
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		do @(posedge clk); while (busy);

		// reset settings: two stops at zero, all colors black
		push_sample(make_sample(Q_ONE, 1'b1), 1'b1);
		push_sample(make_sample(-Q_ONE, 1'b1), 1'b1);
		drain();

		// ordered three-stop ramp; midpoints land on exact halves
		load_stops(csi_pkg::STOP_COUNT_THREE, -10 * Q_ONE, 0, 20 * Q_ONE,
		           32'h00FF_8010, 32'hFF00_40F0, 32'h80FF_00FF, 1'b0);
		push_sample(make_sample(-10 * Q_ONE - 1, 1'b1), 1'b1);
		push_sample(make_sample(-10 * Q_ONE, 1'b1), 1'b1);
		push_sample(make_sample(-10 * Q_ONE + 1, 1'b1), 1'b1);
		push_sample(make_sample(-5 * Q_ONE, 1'b1), 1'b1);
		push_sample(make_sample(-1, 1'b1), 1'b1);
		push_sample(make_sample(0, 1'b1), 1'b1);
		push_sample(make_sample(1, 1'b1), 1'b1);
		push_sample(make_sample(10 * Q_ONE, 1'b1), 1'b1);
		push_sample(make_sample(20 * Q_ONE - 1, 1'b1), 1'b1);
		push_sample(make_sample(20 * Q_ONE, 1'b1), 1'b1);
		push_sample(make_sample(VAL_MIN, 1'b1), 1'b1);
		push_sample(make_sample(VAL_MAX, 1'b1), 1'b1);
		push_sample(make_sample(VAL_MAX, 1'b0), 1'b1);
		push_sample(make_sample(0, 1'b0), 1'b1);
		drain();

		// widest span; stop count zero behaves as two
		load_stops(2'd0, VAL_MIN, VAL_MAX, 0, 32'h0000_0000, 32'hFFFF_FFFF, 32'h1234_5678, 1'b1);
		push_sample(make_sample(VAL_MIN + 1, 1'b1), 1'b1);
		push_sample(make_sample(0, 1'b1), 1'b1);
		push_sample(make_sample(-1, 1'b1), 1'b1);
		push_sample(make_sample(VAL_MAX - 1, 1'b1), 1'b1);
		drain();

		// equal stops (zero-width segment), stop count one behaves as two
		load_stops(2'd1, 5 * Q_ONE, 5 * Q_ONE, -3 * Q_ONE,
		           32'h1020_3040, 32'hA0B0_C0D0, 32'hFFFF_FFFF, 1'b0);
		push_sample(make_sample(5 * Q_ONE, 1'b1), 1'b1);
		push_sample(make_sample(5 * Q_ONE + 1, 1'b1), 1'b1);
		drain();

		// unordered middle stop
		load_stops(csi_pkg::STOP_COUNT_THREE, 0, -Q_ONE, Q_ONE,
		           32'hFF00_0000, 32'h00FF_0000, 32'h0000_FFFF, 1'b0);
		push_sample(make_sample(Q_ONE / 2, 1'b1), 1'b1);
		push_sample(make_sample(Q_ONE - 1, 1'b1), 1'b1);
		drain();

		for (int ph = 0; ph < RAND_PHASES; ph++)
			run_random_phase(PHASE_ITEMS, ph != RAND_PHASES / 2);

		sb.close_out();
		$display("Sent %0d samples over %0d stop settings; %0d colours checked,",
		         samples_sent, settings_used, sb.checked);
		$display("%0d of them interpolated and %0d non-numeric.", sb.blended, sb.non_numeric);
		if (sb.errs == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
`default_nettype wire

// File: filelist.f
sv/csi_pkg.sv
sv/csi_cfg.sv
sv/csi_seg.sv
sv/csi_lerp.sv
sv/color_scale_interpolator_top.sv
sv/csi_checker.sv
verif/tb_color_scale_interpolator_top.sv
